// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the frame length checker.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition implies consequence in the same cycle.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Condition implies consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/hcifl_pkg.sv =====
// Package of the H4 frame length checker: sizes, codes and word types.
// Depends on nothing; every RTL module imports it.
package hcifl_pkg;

   localparam int MAX_FRAME_BYTES = 2048;
   // count saturates at MAX_FRAME_BYTES + 1
   localparam int CNT_W      = $clog2(MAX_FRAME_BYTES + 2);
   localparam int HDR_BYTES  = 5;
   localparam int HDR_IDX_W  = $clog2(HDR_BYTES);
   // widest declared length: 5 + 65535
   localparam int DECL_W     = 17;

   localparam logic [7:0]  PI_ACL   = 8'h02;
   localparam logic [7:0]  PI_SYNC  = 8'h03;
   localparam logic [7:0]  PI_EVENT = 8'h04;
   localparam logic [7:0]  PI_ISO   = 8'h05;

   localparam logic [15:0] ISO_LEN_MASK = 16'h3FFF;

   localparam logic [2:0]  HDR_ACL   = 3'd5;
   localparam logic [2:0]  HDR_SYNC  = 3'd4;
   localparam logic [2:0]  HDR_EVENT = 3'd3;
   localparam logic [2:0]  HDR_NONE  = 3'd0;

   typedef enum logic [2:0] {
      KIND_ACL     = 3'd0,
      KIND_SYNC    = 3'd1,
      KIND_EVENT   = 3'd2,
      KIND_ISO     = 3'd3,
      KIND_UNKNOWN = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      V_COMPLETE = 3'd0,
      V_TOO_LONG = 3'd1,
      V_UNKNOWN  = 3'd2,
      V_SHORT    = 3'd3,
      V_MISMATCH = 3'd4
   } verdict_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
   } word_type;

   typedef struct packed {
      logic        complete;
      kind_type    packet_kind;
      verdict_type verdict;
   } result_type;

   // pipeline control from the input stage to the frame tracker and result register
   typedef struct packed {
      logic advance;
      logic load_result;
   } ctrl_type;

endpackage

// ===== rtl/hci_h4_frame_length_checker_core.sv =====
// Top level of the H4 frame length checker: input register, frame tracker,
// result register. Depends on hcifl_pkg, hcifl_in_reg, hcifl_frame_track,
// hcifl_out_reg and assert_macros.svh.

// Checks the length of controller-to-host H4 frames fed one byte per word on
// the req_ channel, with req_last_byte set on the final byte. The first byte
// is the packet indicator (0x02 ACL, 0x03 synchronous, 0x04 event, 0x05 ISO);
// the header bytes that follow give the declared length, which is compared
// with the byte count (saturating just past 2048 bytes) when the last byte
// arrives. Exactly one rsp_ word comes out per frame, carrying the verdict in
// priority order too long, unknown type, header short, length mismatch, else
// complete. The block takes one byte word per clock while req_stall is low: a
// byte waits in the input register, and the count, header update and verdict
// are worked out in the cycle it leaves it, so the frame state register closes
// a loop on itself. The verdict appears on rsp_ in the cycle after that. A
// waiting verdict stalls only the last byte of the next frame; earlier bytes
// keep flowing. No clearing pass follows reset: the block accepts bytes at once.
module hci_h4_frame_length_checker_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_byte_value,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_complete,
   output logic [2:0] rsp_packet_kind,
   output logic [2:0] rsp_verdict
);
   import hcifl_pkg::*;

`include "assert_macros.svh"

   word_type   req_word;
   word_type   s1_word;
   ctrl_type   ctrl;
   result_type result;
   result_type rsp_result;
   logic       out_free;

   assign req_word.byte_value = req_byte_value;
   assign req_word.last_byte  = req_last_byte;

   // hold the incoming byte in the input register
   hcifl_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .out_free  (out_free),
      .s1_word   (s1_word),
      .ctrl      (ctrl)
   );

   // count the byte, capture the header, judge the frame on its last byte
   hcifl_frame_track u_frame_track (
      .clock   (clock),
      .reset   (reset),
      .s1_word (s1_word),
      .ctrl    (ctrl),
      .result  (result)
   );

   // hold the verdict until the receiver takes it
   hcifl_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .result     (result),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result),
      .out_free   (out_free)
   );

   assign rsp_complete    = rsp_result.complete;
   assign rsp_packet_kind = rsp_result.packet_kind;
   assign rsp_verdict     = rsp_result.verdict;

   // complete flag agrees with the verdict code
   `ASSERT_IMPL(a_complete_matches, clock, reset, rsp_valid,
                rsp_complete == (rsp_verdict == V_COMPLETE))
   // an unknown-type verdict always carries the unknown kind
   `ASSERT_IMPL(a_unknown_kind, clock, reset, rsp_valid && (rsp_verdict == V_UNKNOWN),
                rsp_packet_kind == KIND_UNKNOWN)
   // a last byte that leaves the input stage always shows up as a result
   `ASSERT_NEXT(a_result_loaded, clock, reset, ctrl.load_result, rsp_valid)

endmodule

// ===== rtl/hcifl_in_reg.sv =====
// Input register of the H4 frame length checker with its stall logic.
// Depends on hcifl_pkg.
module hcifl_in_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  hcifl_pkg::word_type req_word,
   input  logic                out_free,
   output hcifl_pkg::word_type s1_word,
   output hcifl_pkg::ctrl_type ctrl
);
   import hcifl_pkg::*;

   logic     s1_valid_ff, s1_valid_in;
   word_type s1_word_ff;
   logic     accept;

   // a word without the last mark never needs the result register
   assign ctrl.advance     = s1_valid_ff && (!s1_word_ff.last_byte || out_free);
   assign ctrl.load_result = ctrl.advance && s1_word_ff.last_byte;
   assign req_stall        = s1_valid_ff && !ctrl.advance;
   assign accept           = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (ctrl.advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_word_ff <= req_word;
      end
   end

   assign s1_word = s1_word_ff;

endmodule

// ===== rtl/hcifl_frame_track.sv =====
// Frame state (byte count, header bytes) and end-of-frame verdict logic.
// Depends on hcifl_pkg.
module hcifl_frame_track (
   input  logic                  clock,
   input  logic                  reset,
   input  hcifl_pkg::word_type   s1_word,
   input  hcifl_pkg::ctrl_type   ctrl,
   output hcifl_pkg::result_type result
);
   import hcifl_pkg::*;

   localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_FRAME_BYTES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);
   localparam logic [CNT_W-1:0] CNT_HDR = CNT_W'(HDR_BYTES);

   logic [CNT_W-1:0]  count_ff, count_in, count_cur;
   logic [7:0]        hdr_ff [HDR_BYTES];
   logic [7:0]        hdr_in [HDR_BYTES];
   logic [7:0]        hdr_cur [HDR_BYTES];
   logic [15:0]       len16;
   logic [DECL_W-1:0] declared;
   logic [2:0]        need;
   kind_type          kind;
   verdict_type       verdict;

   // fold the current byte into the header and count it
   always_comb begin
      for (int i = 0; i < HDR_BYTES; i++) begin
         hdr_cur[i] = hdr_ff[i];
      end
      if (count_ff < CNT_HDR) begin
         hdr_cur[count_ff[HDR_IDX_W-1:0]] = s1_word.byte_value;
      end
      count_cur = (count_ff < CNT_SAT) ? count_ff + 1'b1 : count_ff;
   end

   always_comb begin
      len16 = {hdr_cur[4], hdr_cur[3]};
      case (hdr_cur[0])
         PI_ACL: begin
            kind     = KIND_ACL;
            need     = HDR_ACL;
            declared = DECL_W'(len16) + DECL_W'(HDR_ACL);
         end
         PI_SYNC: begin
            kind     = KIND_SYNC;
            need     = HDR_SYNC;
            declared = DECL_W'(hdr_cur[3]) + DECL_W'(HDR_SYNC);
         end
         PI_EVENT: begin
            kind     = KIND_EVENT;
            need     = HDR_EVENT;
            declared = DECL_W'(hdr_cur[2]) + DECL_W'(HDR_EVENT);
         end
         PI_ISO: begin
            kind     = KIND_ISO;
            need     = HDR_ACL;
            declared = DECL_W'(len16 & ISO_LEN_MASK) + DECL_W'(HDR_ACL);
         end
         default: begin
            kind     = KIND_UNKNOWN;
            need     = HDR_NONE;
            declared = '0;
         end
      endcase

      if (count_cur > CNT_MAX) begin
         verdict = V_TOO_LONG;
      end else if (kind == KIND_UNKNOWN) begin
         verdict = V_UNKNOWN;
      end else if (count_cur < CNT_W'(need)) begin
         verdict = V_SHORT;
      end else if (DECL_W'(count_cur) != declared) begin
         verdict = V_MISMATCH;
      end else begin
         verdict = V_COMPLETE;
      end

      result.complete    = (verdict == V_COMPLETE);
      result.packet_kind = kind;
      result.verdict     = verdict;
   end

   // advance the frame state; drop it at the end of a frame
   always_comb begin
      count_in = count_ff;
      for (int i = 0; i < HDR_BYTES; i++) begin
         hdr_in[i] = hdr_ff[i];
      end
      if (ctrl.advance) begin
         if (s1_word.last_byte) begin
            count_in = '0;
            for (int i = 0; i < HDR_BYTES; i++) begin
               hdr_in[i] = '0;
            end
         end else begin
            count_in = count_cur;
            for (int i = 0; i < HDR_BYTES; i++) begin
               hdr_in[i] = hdr_cur[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < HDR_BYTES; i++) begin
            hdr_ff[i] <= '0;
         end
      end else begin
         count_ff <= count_in;
         for (int i = 0; i < HDR_BYTES; i++) begin
            hdr_ff[i] <= hdr_in[i];
         end
      end
   end

endmodule

// ===== rtl/hcifl_out_reg.sv =====
// Result register of the H4 frame length checker.
// Depends on hcifl_pkg.
module hcifl_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  hcifl_pkg::ctrl_type   ctrl,
   input  hcifl_pkg::result_type result,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output hcifl_pkg::result_type rsp_result,
   output logic                  out_free
);
   import hcifl_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_result_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_result) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

endmodule
